[src/tdq_pkg.sv]
// shared types and constants for the tail-drop queue delay model
// no dependencies; imported by the model unit and the checker
package tdq_pkg;

    // transfer codes on the input channel
    localparam logic OP_ARRIVAL = 1'b0;
    localparam logic OP_DRAIN   = 1'b1;

    // configuration register indexes
    typedef logic [0:0] cfg_index_t;
    localparam cfg_index_t CFG_BYTE_TICKS  = 1'b0;
    localparam cfg_index_t CFG_QUEUE_LIMIT = 1'b1;

    localparam logic [15:0] BYTE_TICKS_RESET  = 16'd1600;
    localparam logic [7:0]  QUEUE_LIMIT_RESET = 8'd100;

    localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
    localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
    localparam logic [63:0] MAX64 = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic        operation;
        logic [47:0] arrival_time;
        logic [15:0] packet_size;
    } in_item_t;

    typedef struct packed {
        logic        admitted;
        logic [47:0] link_time;
        logic [31:0] count_admitted;
        logic [47:0] bytes_admitted;
        logic [31:0] count_sent;
        logic [47:0] bytes_sent;
        logic [31:0] count_dropped;
        logic [47:0] bytes_dropped;
        logic [7:0]  count_waiting;
        logic [23:0] bytes_waiting;
        logic [63:0] delay_total;
    } out_item_t;

endpackage

[src/tdq_ram.sv]
// generic single-write, single-read memory with registered read data
// no dependencies; holds the waiting packets of the queue
module tdq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[src/tdq_sat_add.sv]
// shared saturating adder: one wide add and one compare against a limit
// depends on nothing; used by the sequencer for the delay total, link time and sent, admitted and dropped byte updates
module tdq_sat_add (
    input  logic [63:0] a,
    input  logic [63:0] b,
    input  logic [63:0] limit,
    output logic [63:0] sum
);

    logic [64:0] full;

    always_comb
    begin
        full = {1'b0, a} + {1'b0, b};
        // operand a never exceeds the limit, so clamping the sum is enough
        if (full > {1'b0, limit})
        begin
            sum = limit;
        end
        else
        begin
            sum = full[63:0];
        end
    end

endmodule

[src/tail_drop_queue_delay_model_unit.sv]
// Tail-drop FIFO link buffer model timed in integer ticks. An arrival transfer
// first lets the link serve waiting packets while the link time is below the
// arrival time, then admits the packet stamped with the link time if fewer
// than queue_limit packets wait, or drops it. A drain transfer serves every
// waiting packet. Each input transfer yields one output transfer with the
// running counters. Sequence: an arrival passes the decide, admit and done
// states, a drain the decide and done states, and every packet served adds
// the serve decision, the queue memory read and the single shared
// saturating adder, which updates the delay total, link time and sent
// bytes one after another. The last step also waits for as long as the
// previous result still sits untaken in the output register. The input
// side takes a new transfer while a finished result still waits on the
// output register.
module tail_drop_queue_delay_model_unit #(
    parameter int QUEUE_DEPTH = 128,
    parameter int TIME_WIDTH  = 48
) (
    input  logic               clk,
    input  logic               rst_n,
    // input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  tdq_pkg::in_item_t  in_data,
    // output channel
    output logic               out_valid,
    input  logic               out_stall,
    output tdq_pkg::out_item_t out_data,
    // configuration write port
    input  logic               cfg_write,
    input  tdq_pkg::cfg_index_t cfg_index,
    input  logic [15:0]        cfg_data
);

    import tdq_pkg::*;

    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int OCC_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W = TIME_WIDTH + 16;
    localparam logic [63:0] TIME_MAX = 64'({TIME_WIDTH{1'b1}});
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    // sequencer states, one-hot
    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,  // waiting for an input transfer
        S_DECIDE = 8'b0000_0010,  // serve next packet, or admit / drop / finish
        S_LOAD   = 8'b0000_0100,  // head entry arrives from memory
        S_DELAY  = 8'b0000_1000,  // shared adder: delay total
        S_TIME   = 8'b0001_0000,  // shared adder: link time
        S_BYTES  = 8'b0010_0000,  // shared adder: bytes sent
        S_ADMIT  = 8'b0100_0000,  // shared adder: bytes admitted or dropped
        S_DONE   = 8'b1000_0000   // hand the result to the output register
    } state_t;

    // control and statistic state
    state_t                state_reg, state_next;
    logic [15:0]           byte_ticks_reg, byte_ticks_next;
    logic [7:0]            queue_limit_reg, queue_limit_next;
    logic [OCC_W-1:0]      occ_reg, occ_next;
    logic [PTR_W-1:0]      head_reg, head_next;
    logic [PTR_W-1:0]      tail_reg, tail_next;
    logic [TIME_WIDTH-1:0] time_reg, time_next;
    logic [31:0]           cnt_in_reg, cnt_in_next;
    logic [47:0]           bytes_adm_reg, bytes_adm_next;
    logic [31:0]           cnt_out_reg, cnt_out_next;
    logic [47:0]           bytes_sent_reg, bytes_sent_next;
    logic [31:0]           cnt_drop_reg, cnt_drop_next;
    logic [47:0]           bytes_drop_reg, bytes_drop_next;
    logic [23:0]           bytes_wait_reg, bytes_wait_next;
    logic [63:0]           delay_reg, delay_next;
    logic                  out_valid_reg, out_valid_next;

    // working registers of the current item
    logic                  op_reg, op_next;
    logic [TIME_WIDTH-1:0] arr_reg, arr_next;
    logic [15:0]           size_reg, size_next;
    logic [TIME_WIDTH-1:0] wait_reg, wait_next;
    logic [31:0]           prod_reg, prod_next;
    logic [15:0]           srv_size_reg, srv_size_next;
    logic                  admitted_reg, admitted_next;
    out_item_t             out_data_reg, out_data_next;

    // queue memory
    logic                  ram_we;
    logic [PTR_W-1:0]      ram_waddr;
    logic [ENTRY_W-1:0]    ram_wdata;
    logic                  ram_re;
    logic [ENTRY_W-1:0]    ram_rdata;
    logic [TIME_WIDTH-1:0] rd_stamp;
    logic [15:0]           rd_size;

    // shared adder
    logic [63:0]           add_a, add_b, add_limit, add_sum;

    // helpers
    logic [63:0]           arr_wide;
    logic [63:0]           time_wide;
    logic [31:0]           occ_wide;
    logic [31:0]           limit_eff;
    logic                  time_lt;
    logic                  fits;
    logic [TIME_WIDTH-1:0] stamp;

    tdq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (head_reg),
        .rd_data (ram_rdata)
    );

    tdq_sat_add u_add (
        .a     (add_a),
        .b     (add_b),
        .limit (add_limit),
        .sum   (add_sum)
    );

    assign rd_stamp = ram_rdata[ENTRY_W-1:16];
    assign rd_size  = ram_rdata[15:0];

    // arrival time is cut to the link time width
    assign arr_wide  = 64'(in_data.arrival_time);
    assign time_wide = 64'(time_reg);
    assign occ_wide  = 32'(occ_reg);

    // a limit above the memory depth acts as the depth
    assign limit_eff = (32'(queue_limit_reg) > 32'(QUEUE_DEPTH)) ?
                       32'(QUEUE_DEPTH) : 32'(queue_limit_reg);
    assign fits      = occ_wide < limit_eff;
    assign time_lt   = time_reg < arr_reg;
    // with nothing left to serve, the link idles up to the arrival
    assign stamp     = time_lt ? arr_reg : time_reg;

    // operand selection for the shared adder
    always_comb
    begin
        add_a     = '0;
        add_b     = '0;
        add_limit = '0;
        unique case (state_reg)
            S_DELAY:
            begin
                add_a     = delay_reg;
                add_b     = 64'(wait_reg);
                add_limit = MAX64;
            end
            S_TIME:
            begin
                add_a     = time_wide;
                add_b     = 64'(prod_reg);
                add_limit = TIME_MAX;
            end
            S_BYTES:
            begin
                add_a     = 64'(bytes_sent_reg);
                add_b     = 64'(srv_size_reg);
                add_limit = 64'(MAX48);
            end
            S_ADMIT:
            begin
                add_a     = admitted_reg ? 64'(bytes_adm_reg) : 64'(bytes_drop_reg);
                add_b     = 64'(size_reg);
                add_limit = 64'(MAX48);
            end
            default:
            begin
                add_a     = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        byte_ticks_next  = byte_ticks_reg;
        queue_limit_next = queue_limit_reg;
        occ_next         = occ_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        time_next        = time_reg;
        cnt_in_next      = cnt_in_reg;
        bytes_adm_next   = bytes_adm_reg;
        cnt_out_next     = cnt_out_reg;
        bytes_sent_next  = bytes_sent_reg;
        cnt_drop_next    = cnt_drop_reg;
        bytes_drop_next  = bytes_drop_reg;
        bytes_wait_next  = bytes_wait_reg;
        delay_next       = delay_reg;
        op_next          = op_reg;
        arr_next         = arr_reg;
        size_next        = size_reg;
        wait_next        = wait_reg;
        prod_next        = prod_reg;
        srv_size_next    = srv_size_reg;
        admitted_next    = admitted_reg;
        out_data_next    = out_data_reg;
        ram_we           = 1'b0;
        ram_waddr        = tail_reg;
        ram_wdata        = {stamp, size_reg};
        ram_re           = 1'b0;

        // output register empties on a transfer
        out_valid_next = out_valid_reg & out_stall;

        // configuration writes must only arrive while the block is idle; the block does not enforce this
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_BYTE_TICKS:  byte_ticks_next  = cfg_data;
                CFG_QUEUE_LIMIT: queue_limit_next = cfg_data[7:0];
                default:         byte_ticks_next  = byte_ticks_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = in_data.operation;
                    arr_next   = arr_wide[TIME_WIDTH-1:0];
                    size_next  = in_data.packet_size;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (occ_reg != '0 && (op_reg == OP_DRAIN || time_lt))
                begin
                    // fetch the head packet
                    ram_re     = 1'b1;
                    state_next = S_LOAD;
                end
                else if (op_reg == OP_DRAIN)
                begin
                    admitted_next = 1'b0;
                    state_next    = S_DONE;
                end
                else
                begin
                    time_next = stamp;
                    if (fits)
                    begin
                        ram_we          = 1'b1;
                        tail_next       = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
                        occ_next        = occ_reg + 1'b1;
                        bytes_wait_next = bytes_wait_reg + 24'(size_reg);
                        cnt_in_next     = (cnt_in_reg == MAX32) ? cnt_in_reg
                                                                : cnt_in_reg + 1'b1;
                        admitted_next   = 1'b1;
                    end
                    else
                    begin
                        cnt_drop_next = (cnt_drop_reg == MAX32) ? cnt_drop_reg
                                                                : cnt_drop_reg + 1'b1;
                        admitted_next = 1'b0;
                    end
                    state_next = S_ADMIT;
                end
            end
            S_LOAD:
            begin
                // stamps never run ahead of the link time, but guard anyway
                wait_next       = (time_reg >= rd_stamp) ? time_reg - rd_stamp : '0;
                prod_next       = 32'(rd_size) * 32'(byte_ticks_reg);
                srv_size_next   = rd_size;
                cnt_out_next    = (cnt_out_reg == MAX32) ? cnt_out_reg : cnt_out_reg + 1'b1;
                bytes_wait_next = bytes_wait_reg - 24'(rd_size);
                head_next       = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
                occ_next        = occ_reg - 1'b1;
                state_next      = S_DELAY;
            end
            S_DELAY:
            begin
                delay_next = add_sum;
                state_next = S_TIME;
            end
            S_TIME:
            begin
                time_next  = add_sum[TIME_WIDTH-1:0];
                state_next = S_BYTES;
            end
            S_BYTES:
            begin
                bytes_sent_next = add_sum[47:0];
                state_next      = S_DECIDE;
            end
            S_ADMIT:
            begin
                if (admitted_reg)
                begin
                    bytes_adm_next = add_sum[47:0];
                end
                else
                begin
                    bytes_drop_next = add_sum[47:0];
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_data_next.admitted       = admitted_reg;
                    out_data_next.link_time      = time_wide[47:0];
                    out_data_next.count_admitted = cnt_in_reg;
                    out_data_next.bytes_admitted = bytes_adm_reg;
                    out_data_next.count_sent     = cnt_out_reg;
                    out_data_next.bytes_sent     = bytes_sent_reg;
                    out_data_next.count_dropped  = cnt_drop_reg;
                    out_data_next.bytes_dropped  = bytes_drop_reg;
                    out_data_next.count_waiting  = occ_wide[7:0];
                    out_data_next.bytes_waiting  = bytes_wait_reg;
                    out_data_next.delay_total    = delay_reg;
                    out_valid_next               = 1'b1;
                    state_next                   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and statistic registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            byte_ticks_reg  <= BYTE_TICKS_RESET;
            queue_limit_reg <= QUEUE_LIMIT_RESET;
            occ_reg         <= '0;
            head_reg        <= '0;
            tail_reg        <= '0;
            time_reg        <= '0;
            cnt_in_reg      <= '0;
            bytes_adm_reg   <= '0;
            cnt_out_reg     <= '0;
            bytes_sent_reg  <= '0;
            cnt_drop_reg    <= '0;
            bytes_drop_reg  <= '0;
            bytes_wait_reg  <= '0;
            delay_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            byte_ticks_reg  <= byte_ticks_next;
            queue_limit_reg <= queue_limit_next;
            occ_reg         <= occ_next;
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            time_reg        <= time_next;
            cnt_in_reg      <= cnt_in_next;
            bytes_adm_reg   <= bytes_adm_next;
            cnt_out_reg     <= cnt_out_next;
            bytes_sent_reg  <= bytes_sent_next;
            cnt_drop_reg    <= cnt_drop_next;
            bytes_drop_reg  <= bytes_drop_next;
            bytes_wait_reg  <= bytes_wait_next;
            delay_reg       <= delay_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        arr_reg      <= arr_next;
        size_reg     <= size_next;
        wait_reg     <= wait_next;
        prod_reg     <= prod_next;
        srv_size_reg <= srv_size_next;
        admitted_reg <= admitted_next;
        out_data_reg <= out_data_next;
    end

    // busy for the whole item; a waiting result does not hold off the input
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[src/tdq_checker.sv]
// port-level checks for the tail-drop queue delay model
// depends on tdq_pkg; bound to tail_drop_queue_delay_model_unit below
module tdq_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input tdq_pkg::out_item_t out_data
);

    import tdq_pkg::*;

    // a stalled result stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // the block is busy in the cycle after an accepted transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again straight after a transfer");

    // an admitted packet is counted and waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.admitted |->
            out_data.count_admitted != '0 && out_data.count_waiting != '0)
        else $error("admitted packet missing from counters");

    // an empty queue holds no bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.count_waiting == '0 |-> out_data.bytes_waiting == '0)
        else $error("bytes waiting in an empty queue");

endmodule

bind tail_drop_queue_delay_model_unit tdq_checker u_tdq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
